/* rtl/ddo_pkg.sv */
// Shared widths, constants, codes and the CORDIC angle table for the odometry block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 20;

  // field widths
  localparam int POS_W     = 32;
  localparam int HEAD_W    = 25;
  localparam int CONF_W    = 23;
  localparam int SPACE_W   = 21;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // datapath widths
  localparam int ANG_W   = 42;                    // degrees, 32 fraction bits
  localparam int VEC_W   = 44;                    // CORDIC x/y
  localparam int NORM_W  = 40;                    // vectoring prescale target
  localparam int SUM_W   = SPACE_W + 2;           // wheel sum/difference when in limit
  localparam int TRIG_W  = 34;                    // sine/cosine, 30 fraction bits
  localparam int PROD_W  = SUM_W + TRIG_W;
  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int BIT_W   = $clog2(SUM_W);
  localparam int NUM_W   = 30;                    // decay numerator
  localparam int CF_W    = CONF_W + NUM_W;
  localparam int CFCNT_W = $clog2(CONF_W);
  localparam int ANG_SH  = 32 - FRAC_BITS;

  localparam longint ONE       = 64'sd1 <<< FRAC_BITS;
  localparam longint HALF_F    = 180 * ONE;
  localparam longint FULL_F    = 360 * ONE;
  localparam longint HALF_Q    = 64'sd180 <<< 32;
  localparam longint FULL_Q    = 64'sd360 <<< 32;
  localparam longint QUARTER_Q = 64'sd90 <<< 32;
  localparam longint CORDIC_GAIN = 64'sd652032874;
  localparam longint RAD_TO_DEG_Q32 = 64'sd246083499208;
  localparam longint DECAY_DEN  = 10000 * ONE;
  localparam longint DECAY_NUM0 = DECAY_DEN - ONE;

  // register reset values
  localparam logic [SPACE_W-1:0]       WS_RST = SPACE_W'(124518);
  localparam logic [SPACE_W-1:0]       JL_RST = SPACE_W'(196608);
  localparam logic signed [POS_W-1:0]  SX_RST = POS_W'(65536);
  localparam logic signed [POS_W-1:0]  SY_RST = POS_W'(65536);
  localparam logic signed [HEAD_W-1:0] SH_RST = '0;
  localparam logic [CONF_W-1:0]        SC_RST = CONF_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHEEL_SPACING  = 3'd0,
    CFG_JUMP_LIMIT     = 3'd1,
    CFG_START_X        = 3'd2,
    CFG_START_Y        = 3'd3,
    CFG_START_HEADING  = 3'd4,
    CFG_START_CONF     = 3'd5
  } cfg_idx_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_PREP = 10'b00_0000_0010,
    S_ROT  = 10'b00_0000_0100,
    S_MUL  = 10'b00_0000_1000,
    S_POS  = 10'b00_0001_0000,
    S_NORM = 10'b00_0010_0000,
    S_VEC  = 10'b00_0100_0000,
    S_HEAD = 10'b00_1000_0000,
    S_RND  = 10'b01_0000_0000,
    S_DONE = 10'b10_0000_0000
  } state_t;

  typedef logic signed [ANG_W-1:0] atan_tab_t [CORDIC_STEPS];

  // elaboration only: shift-subtract quotient of two positive values
  function automatic longint div_pos(longint n, longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((n >>> b) & 64'sd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'sd1 <<< b);
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, 32 fraction bits, by its series
  function automatic longint atan_deg(int i);
    longint c52;
    longint sum;
    longint term;
    c52 = RAD_TO_DEG_Q32 * (64'sd1 <<< 20);
    sum = 0;
    if (i == 0) return 64'sd45 <<< 32;
    for (int k = 0; i * (2 * k + 1) < 58; k++) begin
      term = div_pos(c52 >>> (i * (2 * k + 1)), longint'(2 * k + 1));
      sum = (k % 2 == 1) ? sum - term : sum + term;
    end
    return sum >>> 20;
  endfunction

  function automatic atan_tab_t build_atan();
    atan_tab_t t;
    for (int i = 0; i < CORDIC_STEPS; i++) t[i] = ANG_W'(atan_deg(i));
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage
`default_nettype wire

/* rtl/ddo_if.sv */
// Valid/ready channel interfaces for wheel travel items and pose results.
// Depends on ddo_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ddo_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ddo_pkg::POS_W-1:0]  left_change;
  logic signed [ddo_pkg::POS_W-1:0]  right_change;
  modport source (output valid, output left_change, output right_change, input ready);
  modport sink   (input valid, input left_change, input right_change, output ready);
endinterface

interface ddo_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ddo_pkg::POS_W-1:0]  out_x;
  logic signed [ddo_pkg::POS_W-1:0]  out_y;
  logic signed [ddo_pkg::HEAD_W-1:0] out_heading;
  logic [ddo_pkg::CONF_W-1:0]        out_confidence;
  logic                              moved;
  modport source (output valid, output out_x, output out_y, output out_heading,
                  output out_confidence, output moved, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_heading,
                  input out_confidence, input moved, output ready);
endinterface
`default_nettype wire

/* rtl/differential_drive_odometry.sv */
// Differential-drive wheel odometry: pose update per wheel travel transaction.
// Depends on ddo_pkg and the channel interfaces in ddo_if.sv.
//
// Usage:
//  - in_ch carries left/right wheel travel (Q16.16 m) per transaction; out_ch returns one
//    pose transaction (x, y, heading deg, confidence %, moved) per input transaction.
//  - cfg_we/cfg_index/cfg_wdata write a register; writing a start_* register
//    also reloads that part of the kept pose. Write only while the block is idle.
//  - One transaction is worked on at a time; in_ch.ready is high in the idle state.
//  - Work from accept to the load that raises result valid:
//      no travel                      : straight to the load
//      travel over the jump limit     : serial multiply and serial divide in the
//        confidence unit, then the load
//      no turn (zero spacing, equal travel): rotation and position multiply, no arctangent
//      normal step                    : a 20-step CORDIC rotation, a bit-serial
//        position multiply, a 1-bit-per-cycle prescale and a 20-step CORDIC arctangent
//        on the same shared x/y/z unit.
//    The confidence decay runs alongside the CORDIC work.
//  - Throughput: the next transaction is accepted the cycle after the result loads.
//  - Reset loads the config registers with their defaults and the pose with the start values.
//  - The result sits in an output register: a stalled receiver does not stop the next
//    transaction from being accepted and worked on; only its final load waits.
`timescale 1ns / 1ps
`default_nettype none
module differential_drive_odometry (
  input  logic                                clk,
  input  logic                                rst_n,
  ddo_in_if.sink                              in_ch,
  ddo_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int ANG_W   = ddo_pkg::ANG_W;
  localparam int VEC_W   = ddo_pkg::VEC_W;
  localparam int NORM_W  = ddo_pkg::NORM_W;
  localparam int SUM_W   = ddo_pkg::SUM_W;
  localparam int TRIG_W  = ddo_pkg::TRIG_W;
  localparam int PROD_W  = ddo_pkg::PROD_W;
  localparam int STEP_W  = ddo_pkg::STEP_W;
  localparam int BIT_W   = ddo_pkg::BIT_W;
  localparam int NUM_W   = ddo_pkg::NUM_W;
  localparam int CF_W    = ddo_pkg::CF_W;
  localparam int CFCNT_W = ddo_pkg::CFCNT_W;
  localparam int POS_W   = ddo_pkg::POS_W;
  localparam int HEAD_W  = ddo_pkg::HEAD_W;
  localparam int CONF_W  = ddo_pkg::CONF_W;
  localparam int SPACE_W = ddo_pkg::SPACE_W;
  localparam int ANG_SH  = ddo_pkg::ANG_SH;

  localparam logic signed [PROD_W-1:0] RND_Q30  = PROD_W'(64'sd1 <<< 30);
  localparam logic signed [ANG_W-1:0]  RND_HEAD = ANG_W'(64'sd1 <<< (ANG_SH - 1));
  localparam logic [CF_W-1:0]          DSH0     =
    CF_W'(ddo_pkg::DECAY_DEN) << (CONF_W - 1);

  // ---------------------------------------------------------------- registers
  ddo_pkg::state_t state_r;

  logic [SPACE_W-1:0]       wheel_spacing_r, jump_limit_r;

  logic signed [POS_W-1:0]  pose_x_r, pose_y_r;
  logic signed [HEAD_W-1:0] pose_heading_r;
  logic [CONF_W-1:0]        pose_conf_r;

  logic                     jump_ok_r, moved_r, flip_r, vec_r;
  logic signed [SUM_W-1:0]  sum_r, dif_r;
  logic signed [ANG_W-1:0]  hq_r;
  logic signed [VEC_W-1:0]  cx_r, cy_r;
  logic signed [ANG_W-1:0]  cz_r;
  logic [STEP_W-1:0]        cnt_r;
  logic signed [TRIG_W-1:0] cc_r, cs_r;
  logic signed [PROD_W-1:0] acc_x_r, acc_y_r;
  logic [BIT_W-1:0]         mb_r;
  logic [NORM_W-1:0]        nm_r;

  logic                     cf_busy_r, cf_div_r;
  logic [CFCNT_W-1:0]       cf_cnt_r;
  logic [NUM_W-1:0]         cf_num_r;
  logic [CF_W-1:0]          cf_acc_r, cf_dsh_r;
  logic [CONF_W-1:0]        cf_q_r, cf_src_r;

  logic                     out_valid_r, om_r;
  logic signed [POS_W-1:0]  ox_r, oy_r;
  logic signed [HEAD_W-1:0] oh_r;
  logic [CONF_W-1:0]        oc_r;

  // ---------------------------------------------------------------- input decode
  logic                     in_acc, moved_w, jump_ok_w;
  logic signed [32:0]       l_x, r_x, sum_w, dif_w;
  logic [32:0]              al, ar, turn;
  logic signed [37:0]       num_w;

  assign in_ch.ready = (state_r == ddo_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    l_x   = 33'(in_ch.left_change);
    r_x   = 33'(in_ch.right_change);
    sum_w = l_x + r_x;
    dif_w = r_x - l_x;
    al    = l_x[32] ? 33'(-l_x) : l_x;
    ar    = r_x[32] ? 33'(-r_x) : r_x;
    turn  = dif_w[32] ? 33'(-dif_w) : dif_w;
    // decay numerator: (1 - 0.0001 - 0.001*turn) scaled by 10000
    num_w = 38'(ddo_pkg::DECAY_NUM0) - ({5'b0, turn} * 38'd10);
    moved_w   = (in_ch.left_change != '0) || (in_ch.right_change != '0);
    jump_ok_w = (al < {12'b0, jump_limit_r}) && (ar < {12'b0, jump_limit_r});
  end

  // ---------------------------------------------------------------- heading prep
  logic signed [25:0]      hx, hw;
  logic signed [ANG_W-1:0] hq_p, z_p;
  logic                    flip_p;

  always_comb begin
    hx = 26'(pose_heading_r);
    if (hx > 26'(ddo_pkg::HALF_F)) begin
      hw = hx - 26'(ddo_pkg::FULL_F);
    end else if (hx <= -26'(ddo_pkg::HALF_F)) begin
      hw = hx + 26'(ddo_pkg::FULL_F);
    end else begin
      hw = hx;
    end
    hq_p = ANG_W'(hw) <<< ANG_SH;
    // fold into +-90 for the rotation, negate the result afterwards
    if (hq_p > ANG_W'(ddo_pkg::QUARTER_Q)) begin
      z_p    = hq_p - ANG_W'(ddo_pkg::HALF_Q);
      flip_p = 1'b1;
    end else if (hq_p < -ANG_W'(ddo_pkg::QUARTER_Q)) begin
      z_p    = hq_p + ANG_W'(ddo_pkg::HALF_Q);
      flip_p = 1'b1;
    end else begin
      z_p    = hq_p;
      flip_p = 1'b0;
    end
  end

  // ---------------------------------------------------------------- shared CORDIC step
  logic signed [VEC_W-1:0] dx, dy, cx_nxt, cy_nxt;
  logic signed [ANG_W-1:0] tt, cz_nxt;
  logic                    dir_pos, last_step;

  always_comb begin
    // x moves by y >> i, y moves by x >> i
    dx = cy_r >>> cnt_r;
    dy = cx_r >>> cnt_r;
    tt = ddo_pkg::ATAN_TAB[cnt_r];
    // rotation steers on z, vectoring drives y to zero
    dir_pos = vec_r ? !(cy_r > 0) : !cz_r[ANG_W-1];
    if (dir_pos) begin
      cx_nxt = cx_r - dx;
      cy_nxt = cy_r + dy;
      cz_nxt = cz_r - tt;
    end else begin
      cx_nxt = cx_r + dx;
      cy_nxt = cy_r - dy;
      cz_nxt = cz_r + tt;
    end
    last_step = (cnt_r == STEP_W'(ddo_pkg::CORDIC_STEPS - 1));
  end

  // ---------------------------------------------------------------- bit-serial position multiply
  logic signed [PROD_W-1:0] cc_e, cs_e, acx_nxt, acy_nxt, rnd_x, rnd_y;
  logic                     mbit, mb_first;
  logic signed [32:0]       px_w, py_w;
  logic signed [POS_W-1:0]  px_s, py_s;

  always_comb begin
    cc_e     = PROD_W'(cc_r);
    cs_e     = PROD_W'(cs_r);
    mbit     = sum_r[mb_r];
    mb_first = (mb_r == BIT_W'(SUM_W - 1));
    // MSB first; the sign bit carries negative weight
    acx_nxt  = (acc_x_r <<< 1) + (mbit ? (mb_first ? -cc_e : cc_e) : '0);
    acy_nxt  = (acc_y_r <<< 1) + (mbit ? (mb_first ? -cs_e : cs_e) : '0);
    rnd_x    = (acc_x_r + RND_Q30) >>> 31;
    rnd_y    = (acc_y_r + RND_Q30) >>> 31;
    px_w     = 33'(pose_x_r) + 33'(rnd_x);
    py_w     = 33'(pose_y_r) + 33'(rnd_y);
    px_s     = (px_w[32] != px_w[31]) ? (px_w[32] ? {1'b1, {(POS_W-1){1'b0}}}
                                                  : {1'b0, {(POS_W-1){1'b1}}})
                                      : px_w[POS_W-1:0];
    py_s     = (py_w[32] != py_w[31]) ? (py_w[32] ? {1'b1, {(POS_W-1){1'b0}}}
                                                  : {1'b0, {(POS_W-1){1'b1}}})
                                      : py_w[POS_W-1:0];
  end

  // ---------------------------------------------------------------- arctangent setup, heading
  logic                    use_atan;
  logic [SUM_W-1:0]        absd;
  logic [NORM_W-1:0]       nm_init;
  logic signed [ANG_W-1:0] ha, hqw, hr;
  logic signed [25:0]      hf, hf_w;

  always_comb begin
    use_atan = (wheel_spacing_r != '0) || (dif_r != '0);
    absd     = dif_r[SUM_W-1] ? SUM_W'(-dif_r) : dif_r;
    nm_init  = (NORM_W'(absd) > NORM_W'(wheel_spacing_r)) ? NORM_W'(absd)
                                                         : NORM_W'(wheel_spacing_r);
    ha = hq_r + cz_r;
    if (ha > ANG_W'(ddo_pkg::HALF_Q)) begin
      hqw = ha - ANG_W'(ddo_pkg::FULL_Q);
    end else if (ha <= -ANG_W'(ddo_pkg::HALF_Q)) begin
      hqw = ha + ANG_W'(ddo_pkg::FULL_Q);
    end else begin
      hqw = ha;
    end
    hr = (hq_r + RND_HEAD) >>> ANG_SH;
    hf = 26'(hr);
    if (hf <= -26'(ddo_pkg::HALF_F)) begin
      hf_w = hf + 26'(ddo_pkg::FULL_F);
    end else if (hf > 26'(ddo_pkg::HALF_F)) begin
      hf_w = hf - 26'(ddo_pkg::FULL_F);
    end else begin
      hf_w = hf;
    end
  end

  // ---------------------------------------------------------------- confidence unit
  logic [CF_W-1:0]   cf_mul_nxt, cf_sub;
  logic              cf_ge, cf_last;
  logic [CONF_W-1:0] cf_q_nxt;

  always_comb begin
    cf_mul_nxt = (cf_acc_r << 1) + (cf_src_r[CONF_W-1] ? CF_W'(cf_num_r) : '0);
    cf_ge      = (cf_acc_r >= cf_dsh_r);
    cf_sub     = cf_acc_r - cf_dsh_r;
    cf_q_nxt   = {cf_q_r[CONF_W-2:0], cf_ge};
    cf_last    = (cf_cnt_r == CFCNT_W'(CONF_W - 1));
  end

  logic out_load;
  assign out_load = (state_r == ddo_pkg::S_DONE) && !cf_busy_r &&
                    (!out_valid_r || out_ch.ready);

  // ---------------------------------------------------------------- control, config, pose
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ddo_pkg::S_IDLE;
      cf_busy_r       <= 1'b0;
      cf_div_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      wheel_spacing_r <= ddo_pkg::WS_RST;
      jump_limit_r    <= ddo_pkg::JL_RST;
      pose_x_r        <= ddo_pkg::SX_RST;
      pose_y_r        <= ddo_pkg::SY_RST;
      pose_heading_r  <= ddo_pkg::SH_RST;
      pose_conf_r     <= ddo_pkg::SC_RST;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ddo_pkg::S_IDLE: begin
          if (in_acc) state_r <= moved_w ? ddo_pkg::S_PREP : ddo_pkg::S_DONE;
        end
        ddo_pkg::S_PREP: state_r <= jump_ok_r ? ddo_pkg::S_ROT : ddo_pkg::S_RND;
        ddo_pkg::S_ROT: begin
          if (last_step) state_r <= ddo_pkg::S_MUL;
        end
        ddo_pkg::S_MUL: begin
          if (mb_r == '0) state_r <= ddo_pkg::S_POS;
        end
        ddo_pkg::S_POS: begin
          pose_x_r <= px_s;
          pose_y_r <= py_s;
          state_r  <= use_atan ? ddo_pkg::S_NORM : ddo_pkg::S_RND;
        end
        ddo_pkg::S_NORM: begin
          if (nm_r[NORM_W-1]) state_r <= ddo_pkg::S_VEC;
        end
        ddo_pkg::S_VEC: begin
          if (last_step) state_r <= ddo_pkg::S_HEAD;
        end
        ddo_pkg::S_HEAD: state_r <= ddo_pkg::S_RND;
        ddo_pkg::S_RND: begin
          pose_heading_r <= HEAD_W'(hf_w);
          state_r        <= ddo_pkg::S_DONE;
        end
        ddo_pkg::S_DONE: begin
          if (out_load) state_r <= ddo_pkg::S_IDLE;
        end
        default: state_r <= ddo_pkg::S_IDLE;
      endcase

      // confidence: zero outright when the factor is not positive
      if (in_acc && moved_w) begin
        if (num_w > 0) begin
          cf_busy_r <= 1'b1;
          cf_div_r  <= 1'b0;
        end else begin
          pose_conf_r <= '0;
        end
      end else if (cf_busy_r) begin
        if (!cf_div_r) begin
          if (cf_last) cf_div_r <= 1'b1;
        end else if (cf_last) begin
          cf_busy_r   <= 1'b0;
          pose_conf_r <= cf_q_nxt;
        end
      end

      if (cfg_we) begin
        unique case (cfg_index)
          ddo_pkg::CFG_WHEEL_SPACING: wheel_spacing_r <= cfg_wdata[SPACE_W-1:0];
          ddo_pkg::CFG_JUMP_LIMIT:    jump_limit_r    <= cfg_wdata[SPACE_W-1:0];
          ddo_pkg::CFG_START_X:       pose_x_r        <= cfg_wdata[POS_W-1:0];
          ddo_pkg::CFG_START_Y:       pose_y_r        <= cfg_wdata[POS_W-1:0];
          ddo_pkg::CFG_START_HEADING: pose_heading_r  <= cfg_wdata[HEAD_W-1:0];
          ddo_pkg::CFG_START_CONF:    pose_conf_r     <= cfg_wdata[CONF_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sum_r     <= sum_w[SUM_W-1:0];
      dif_r     <= dif_w[SUM_W-1:0];
      jump_ok_r <= jump_ok_w;
      moved_r   <= moved_w;
    end

    unique case (state_r)
      ddo_pkg::S_PREP: begin
        hq_r   <= hq_p;
        cx_r   <= VEC_W'(ddo_pkg::CORDIC_GAIN);
        cy_r   <= '0;
        cz_r   <= z_p;
        flip_r <= flip_p;
        vec_r  <= 1'b0;
        cnt_r  <= '0;
      end
      ddo_pkg::S_ROT, ddo_pkg::S_VEC: begin
        cx_r  <= cx_nxt;
        cy_r  <= cy_nxt;
        cz_r  <= cz_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (last_step && !vec_r) begin
          cc_r    <= flip_r ? TRIG_W'(-cx_nxt) : TRIG_W'(cx_nxt);
          cs_r    <= flip_r ? TRIG_W'(-cy_nxt) : TRIG_W'(cy_nxt);
          acc_x_r <= '0;
          acc_y_r <= '0;
          mb_r    <= BIT_W'(SUM_W - 1);
        end
      end
      ddo_pkg::S_MUL: begin
        acc_x_r <= acx_nxt;
        acc_y_r <= acy_nxt;
        mb_r    <= mb_r - 1'b1;
      end
      ddo_pkg::S_POS: begin
        cx_r <= VEC_W'(wheel_spacing_r);
        cy_r <= VEC_W'(dif_r);
        nm_r <= nm_init;
      end
      ddo_pkg::S_NORM: begin
        if (nm_r[NORM_W-1]) begin
          cz_r  <= '0;
          cnt_r <= '0;
          vec_r <= 1'b1;
        end else begin
          cx_r <= cx_r <<< 1;
          cy_r <= cy_r <<< 1;
          nm_r <= nm_r << 1;
        end
      end
      ddo_pkg::S_HEAD: hq_r <= hqw;
      default: ;
    endcase

    // confidence: serial multiply by the numerator, then restoring divide
    if (in_acc) begin
      cf_num_r <= num_w[NUM_W-1:0];
      cf_src_r <= pose_conf_r;
      cf_acc_r <= '0;
      cf_cnt_r <= '0;
    end else if (cf_busy_r) begin
      cf_cnt_r <= cf_last ? '0 : cf_cnt_r + 1'b1;
      if (!cf_div_r) begin
        cf_acc_r <= cf_mul_nxt;
        cf_src_r <= cf_src_r << 1;
        if (cf_last) cf_dsh_r <= DSH0;
      end else begin
        if (cf_ge) cf_acc_r <= cf_sub;
        cf_dsh_r <= cf_dsh_r >> 1;
        cf_q_r   <= cf_q_nxt;
      end
    end

    if (out_load) begin
      ox_r <= pose_x_r;
      oy_r <= pose_y_r;
      oh_r <= pose_heading_r;
      oc_r <= pose_conf_r;
      om_r <= moved_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_x          = ox_r;
  assign out_ch.out_y          = oy_r;
  assign out_ch.out_heading    = oh_r;
  assign out_ch.out_confidence = oc_r;
  assign out_ch.moved          = om_r;

  // ---------------------------------------------------------------- assertions
  a_conf_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ddo_pkg::S_IDLE) |-> !cf_busy_r)
    else $error("confidence unit still busy in idle state");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ddo_pkg::S_NORM) |-> (nm_r != '0))
    else $error("prescale of a zero vector would not terminate");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_ch.valid)
    else $error("result load did not raise valid");

  a_still_no_conf: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ddo_pkg::S_DONE && !moved_r) |-> !cf_busy_r)
    else $error("confidence decay started without travel");

endmodule
`default_nettype wire
